@@ rtl/rdk_pkg.sv @@
`timescale 1ns / 1ps

package rdk_pkg;

  // Event sources
  localparam logic [2:0] FUNC_DIMMER     = 3'd0;
  localparam logic [2:0] FUNC_COMMISSION = 3'd1;
  localparam logic [2:0] FUNC_RELAY      = 3'd2;
  localparam logic [2:0] FUNC_DETENT     = 3'd3;
  localparam logic [2:0] FUNC_TICK       = 3'd4;
  localparam logic [2:0] FUNC_JOINED     = 3'd5;
  localparam logic [2:0] FUNC_LEAVE      = 3'd6;
  localparam logic [2:0] FUNC_RELAY_WR   = 3'd7;

  // Switch events
  localparam logic [2:0] EV_PRESS        = 3'd0;
  localparam logic [2:0] EV_RELEASE      = 3'd1;
  localparam logic [2:0] EV_LONG_PRESS   = 3'd2;
  localparam logic [2:0] EV_LONG_RELEASE = 3'd3;
  localparam logic [2:0] EV_HOLD         = 3'd4;

  // Commands
  localparam logic [2:0] CMD_LED_ONLY    = 3'd0;
  localparam logic [2:0] CMD_TOGGLE      = 3'd1;
  localparam logic [2:0] CMD_OFF         = 3'd2;
  localparam logic [2:0] CMD_LEVEL_STEP  = 3'd3;
  localparam logic [2:0] CMD_COLOR_STEP  = 3'd4;
  localparam logic [2:0] CMD_STEER       = 3'd5;
  localparam logic [2:0] CMD_FACTORY_RST = 3'd6;
  localparam logic [2:0] CMD_RELAY_RPT   = 3'd7;

  // LED codes
  localparam logic [3:0] LED_OFF         = 4'd0;
  localparam logic [3:0] LED_WHITE_ONCE  = 4'd1;
  localparam logic [3:0] LED_RED_ONCE    = 4'd2;
  localparam logic [3:0] LED_YELLOW_ONCE = 4'd3;
  localparam logic [3:0] LED_YELLOW_BLNK = 4'd4;
  localparam logic [3:0] LED_WARN_RED    = 4'd5;
  localparam logic [3:0] LED_RED_BLINK   = 4'd6;
  localparam logic [3:0] LED_BLUE_ONCE   = 4'd7;
  localparam logic [3:0] LED_GREEN_ONCE  = 4'd8;

  // Configuration register indexes
  localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
  localparam logic [2:0] REG_HOLD_TMO    = 3'd1;
  localparam logic [2:0] REG_LEVEL_STEP  = 3'd2;
  localparam logic [2:0] REG_COLOR_STEP  = 3'd3;

  // Reset values of the configuration registers
  localparam logic [15:0] DEBOUNCE_RST   = 16'd50;
  localparam logic [15:0] HOLD_TMO_RST   = 16'd5000;
  localparam logic [7:0]  LEVEL_STEP_RST = 8'd15;
  localparam logic [15:0] COLOR_STEP_RST = 16'd25;

  localparam logic [15:0] HELD_MAX       = 16'hFFFF;

  typedef struct packed {
    logic        button_held;
    logic        turned_while_held;
    logic [15:0] held_ticks;
    logic        network_joined;
    logic        relay_state;
  } state_t;

  typedef struct packed {
    logic [15:0] debounce_window;
    logic [15:0] hold_timeout_ticks;
    logic [7:0]  level_step;
    logic [15:0] color_step;
  } cfg_t;

  typedef struct packed {
    logic [2:0] func;
    logic [2:0] switch_event;
    logic       clockwise;
    logic       leave_rejoin;
    logic       relay_value;
  } event_t;

  typedef struct packed {
    logic        valid;
    logic [2:0]  cmd;
    logic        sent;
    logic        step_up;
    logic [15:0] step_amount;
    logic        relay_on;
    logic [3:0]  led_code;
  } result_t;

endpackage

@@ rtl/rotary_dimmer_knob_controller.sv @@
`timescale 1ns / 1ps
// Channel   Direction  Handshake              Payload
// event     in         in_valid / in_ready    func, switch_event, clockwise,
//                                             leave_rejoin, relay_value
// result    out        out_valid / out_ready  cmd, sent, step_up, step_amount,
//                                             relay_on, led_code
// config    in         cfg_en                 cfg_index, cfg_data
//
// One request per cycle while the result is not stalled; its result, if any, is valid the cycle after acceptance.
// The rate is set by the single result register between decode and output.
// in_ready is high whenever the result register is empty or being drained.
// A stalled result holds; a new request is taken in the cycle it is drained.
// Synchronous reset restores the default configuration and clears the knob state and out_valid.
// Indexes 4 to 7 are accepted but drive no output.

module rotary_dimmer_knob_controller (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [2:0]  func,
  input  logic [2:0]  switch_event,
  input  logic        clockwise,
  input  logic        leave_rejoin,
  input  logic        relay_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [2:0]  cmd,
  output logic        sent,
  output logic        step_up,
  output logic [15:0] step_amount,
  output logic        relay_on,
  output logic [3:0]  led_code,
  input  logic        cfg_en,
  input  logic [2:0]  cfg_index,
  input  logic [15:0] cfg_data
);
  import rdk_pkg::*;

  state_t  state;
  state_t  state_next;
  cfg_t    cfg;
  event_t  ev;
  result_t res;
  logic    accept;

  assign ev = '{func: func, switch_event: switch_event, clockwise: clockwise,
                leave_rejoin: leave_rejoin, relay_value: relay_value};

  assign in_ready = !out_valid || out_ready;
  assign accept   = in_valid && in_ready;

  rdk_decode u_decode (
    .state      (state),
    .cfg        (cfg),
    .ev         (ev),
    .state_next (state_next),
    .res        (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.debounce_window    <= DEBOUNCE_RST;
      cfg.hold_timeout_ticks <= HOLD_TMO_RST;
      cfg.level_step         <= LEVEL_STEP_RST;
      cfg.color_step         <= COLOR_STEP_RST;
    end else if (cfg_en) begin
      case (cfg_index)
        REG_DEBOUNCE:   cfg.debounce_window    <= cfg_data;
        REG_HOLD_TMO:   cfg.hold_timeout_ticks <= cfg_data;
        REG_LEVEL_STEP: cfg.level_step         <= cfg_data[7:0];
        REG_COLOR_STEP: cfg.color_step         <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= '0;
      out_valid <= 1'b0;
    end else if (accept) begin
      state     <= state_next;
      out_valid <= res.valid;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && res.valid) begin
      cmd         <= res.cmd;
      sent        <= res.sent;
      step_up     <= res.step_up;
      step_amount <= res.step_amount;
      relay_on    <= res.relay_on;
      led_code    <= res.led_code;
    end
  end

endmodule

@@ rtl/rdk_decode.sv @@
`timescale 1ns / 1ps

module rdk_decode (
  input  rdk_pkg::state_t  state,
  input  rdk_pkg::cfg_t    cfg,
  input  rdk_pkg::event_t  ev,
  output rdk_pkg::state_t  state_next,
  output rdk_pkg::result_t res
);
  import rdk_pkg::*;

  logic [15:0] held_inc;

  assign held_inc = (state.held_ticks == HELD_MAX) ? state.held_ticks
                                                   : state.held_ticks + 16'd1;

  always_comb begin
    state_next = state;
    res        = '0;
    case (ev.func)
      FUNC_DIMMER: begin
        if (ev.switch_event == EV_PRESS) begin
          state_next.button_held       = 1'b1;
          state_next.turned_while_held = 1'b0;
          state_next.held_ticks        = '0;
        end else if (ev.switch_event inside {EV_RELEASE, EV_LONG_RELEASE}) begin
          state_next.button_held       = 1'b0;
          state_next.turned_while_held = 1'b0;
          // A turn past the debounce window during the press swallows the release command.
          if (!state.turned_while_held) begin
            res.valid    = 1'b1;
            res.cmd      = (ev.switch_event == EV_RELEASE) ? CMD_TOGGLE : CMD_OFF;
            res.sent     = state.network_joined;
            res.led_code = state.network_joined ? LED_WHITE_ONCE : LED_RED_ONCE;
          end
        end else if (!(ev.switch_event inside {EV_LONG_PRESS, EV_HOLD})) begin
          state_next.button_held       = 1'b0;
          state_next.turned_while_held = 1'b0;
        end
      end
      FUNC_COMMISSION: begin
        case (ev.switch_event)
          EV_RELEASE: begin
            res.valid    = 1'b1;
            res.cmd      = CMD_STEER;
            res.sent     = 1'b1;
            res.led_code = LED_YELLOW_ONCE;
          end
          EV_LONG_PRESS: begin
            res.valid    = 1'b1;
            res.cmd      = CMD_LED_ONLY;
            res.led_code = LED_YELLOW_BLNK;
          end
          EV_LONG_RELEASE: begin
            res.valid    = 1'b1;
            res.cmd      = CMD_LED_ONLY;
            res.led_code = state.network_joined ? LED_OFF : LED_WARN_RED;
          end
          EV_HOLD: begin
            res.valid    = 1'b1;
            res.cmd      = CMD_FACTORY_RST;
            res.sent     = 1'b1;
            res.led_code = LED_RED_BLINK;
          end
          default: ;
        endcase
      end
      FUNC_RELAY: begin
        if (ev.switch_event == EV_RELEASE) begin
          state_next.relay_state = !state.relay_state;
          res.valid    = 1'b1;
          res.cmd      = CMD_RELAY_RPT;
          res.sent     = 1'b1;
          res.relay_on = !state.relay_state;
          res.led_code = LED_BLUE_ONCE;
        end
      end
      FUNC_DETENT: begin
        if (!state.button_held) begin
          res.valid       = 1'b1;
          res.cmd         = CMD_LEVEL_STEP;
          res.step_up     = ev.clockwise;
          res.step_amount = {8'd0, cfg.level_step};
          res.sent        = state.network_joined;
          res.led_code    = state.network_joined ? LED_WHITE_ONCE : LED_RED_ONCE;
        end else if (state.held_ticks >= cfg.debounce_window) begin
          state_next.turned_while_held = 1'b1;
          res.valid       = 1'b1;
          res.cmd         = CMD_COLOR_STEP;
          res.step_up     = ev.clockwise;
          res.step_amount = cfg.color_step;
          res.sent        = state.network_joined;
          res.led_code    = state.network_joined ? LED_WHITE_ONCE : LED_RED_ONCE;
        end
      end
      FUNC_TICK: begin
        if (state.button_held) begin
          state_next.held_ticks = held_inc;
          if (held_inc > cfg.hold_timeout_ticks) begin
            state_next.button_held       = 1'b0;
            state_next.turned_while_held = 1'b0;
          end
        end
      end
      FUNC_JOINED: begin
        state_next.network_joined = 1'b1;
        res.valid    = 1'b1;
        res.cmd      = CMD_LED_ONLY;
        res.led_code = LED_GREEN_ONCE;
      end
      FUNC_LEAVE: begin
        if (!ev.leave_rejoin) begin
          state_next.network_joined = 1'b0;
          res.valid    = 1'b1;
          res.cmd      = CMD_LED_ONLY;
          res.led_code = LED_WARN_RED;
        end
      end
      default: begin
        state_next.relay_state = ev.relay_value;
      end
    endcase
  end

endmodule

@@ rtl/rdk_checker.sv @@
`timescale 1ns / 1ps

module rdk_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic [2:0]  cmd,
  input logic        sent,
  input logic        step_up,
  input logic [15:0] step_amount,
  input logic [3:0]  led_code
);
  import rdk_pkg::*;

  // The result register empties on reset.
  a_reset_clears: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid after reset");

  // A waiting result never blocks a request that drains it, and a full one blocks.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("in_ready does not follow the result register");

  // A stalled result holds.
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(cmd) && $stable(led_code)
      && $stable(step_amount))
    else $error("stalled result changed");

  // Only the two step commands carry a direction or a size.
  a_step_fields: assert property (@(posedge clk) disable iff (rst)
    out_valid && cmd != CMD_LEVEL_STEP && cmd != CMD_COLOR_STEP |->
      step_amount == 16'd0 && !step_up)
    else $error("step fields set on a non-step command");

  // A dropped light command shows a single red flash; LED-only never goes out.
  a_drop_led: assert property (@(posedge clk) disable iff (rst)
    out_valid && !sent && cmd != CMD_LED_ONLY |-> led_code == LED_RED_ONCE)
    else $error("dropped command without red LED");

endmodule

bind rotary_dimmer_knob_controller rdk_checker u_rdk_checker (
  .clk         (clk),
  .rst         (rst),
  .in_ready    (in_ready),
  .out_valid   (out_valid),
  .out_ready   (out_ready),
  .cmd         (cmd),
  .sent        (sent),
  .step_up     (step_up),
  .step_amount (step_amount),
  .led_code    (led_code)
);
